// ===== rtl/p1305tc_pkg.sv =====
// ============================================================================
// p1305tc_pkg
// Shared types, constants and codes for the Poly1305 tag checker.
// ============================================================================
package p1305tc_pkg;

    localparam int LIMB_W  = 26;
    localparam int HLIMB_W = 27;
    localparam int NUM_LIMBS = 5;
    localparam int OPA_W   = 28;
    localparam int OPB_W   = 29;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ACC_W   = 64;
    localparam int ROW_W   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [63:0] CLAMP_LOW  = 64'h0fff_fffc_0fff_ffff;
    localparam logic [63:0] CLAMP_HIGH = 64'h0fff_fffc_0fff_fffc;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_R_LOW    = 3'd0,
        CFG_R_HIGH   = 3'd1,
        CFG_S_LOW    = 3'd2,
        CFG_S_HIGH   = 3'd3,
        CFG_TAG_LOW  = 3'd4,
        CFG_TAG_HIGH = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_FOLD,
        ST_FIN_CARRY,
        ST_FIN_SUB,
        ST_FIN_OUT
    } state_t;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic [4:0]  valid_bytes;
        logic        last_block;
    } block_item_t;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
        logic        accept;
    } result_item_t;

    // One multiply-accumulate request from the sequencer.
    typedef struct packed {
        logic             issue;
        logic             first;
        logic             chain;
        logic             row_end;
        logic [ROW_W-1:0] row;
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } mac_ctl_t;

    // A finished row of the limb product.
    typedef struct packed {
        logic             done;
        logic [ROW_W-1:0] row;
        logic [ACC_W-1:0] acc;
    } mac_res_t;

endpackage

// ===== rtl/p1305tc_mac.sv =====
// ============================================================================
// p1305tc_mac
// Shared limb multiplier with a registered product and a row accumulator.
// ============================================================================
module p1305tc_mac (
    input  logic                  clk,
    input  logic                  rst_n,
    input  p1305tc_pkg::mac_ctl_t ctl,
    output p1305tc_pkg::mac_res_t res
);

    logic                                p_valid_reg;
    logic                                p_first_reg;
    logic                                p_chain_reg;
    logic                                p_end_reg;
    logic [p1305tc_pkg::ROW_W-1:0]       p_row_reg;
    logic [p1305tc_pkg::PROD_W-1:0]      prod_reg;

    logic [p1305tc_pkg::ACC_W-1:0]       acc_reg;
    logic [p1305tc_pkg::ACC_W-1:0]       acc_next;
    logic [p1305tc_pkg::ACC_W-1:0]       acc_base;
    logic                                done_reg;
    logic [p1305tc_pkg::ROW_W-1:0]       row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_first_reg <= 1'b0;
            p_chain_reg <= 1'b0;
            p_end_reg   <= 1'b0;
            p_row_reg   <= '0;
            done_reg    <= 1'b0;
            row_reg     <= '0;
        end
        else
        begin
            p_valid_reg <= ctl.issue;
            p_first_reg <= ctl.first;
            p_chain_reg <= ctl.chain;
            p_end_reg   <= ctl.row_end;
            p_row_reg   <= ctl.row;
            done_reg    <= p_valid_reg && p_end_reg;
            row_reg     <= p_row_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= p1305tc_pkg::PROD_W'(ctl.a) * p1305tc_pkg::PROD_W'(ctl.b);
        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // A chained row starts from the carry out of the previous row; row 0 starts from zero.
    always_comb
    begin
        if (!p_first_reg)
        begin
            acc_base = acc_reg;
        end
        else if (p_chain_reg)
        begin
            acc_base = {{p1305tc_pkg::LIMB_W{1'b0}},
                        acc_reg[p1305tc_pkg::ACC_W-1:p1305tc_pkg::LIMB_W]};
        end
        else
        begin
            acc_base = '0;
        end
        acc_next = acc_base + p1305tc_pkg::ACC_W'(prod_reg);
    end

    assign res.done = done_reg;
    assign res.row  = row_reg;
    assign res.acc  = acc_reg;

endmodule

// ===== rtl/poly1305_tag_check.sv =====
// A block with data passes the multiply, drain and fold steps before the
// next block can be taken; a last block then passes the final carry,
// subtract and output steps. An empty last block goes straight to the
// final carry step. The 25 limb products of each block go one per cycle
// through one shared 28x29 multiplier.
// Reset clears the keys, the expected tag and the accumulator to zero.
// ============================================================================
// poly1305_tag_check
// Poly1305 authenticator computed block by block and checked against an
// expected tag held in configuration registers.
// ============================================================================
module poly1305_tag_check (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [p1305tc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                           cfg_data,
    input  logic                                  block_valid,
    output logic                                  block_ready,
    input  p1305tc_pkg::block_item_t              block,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output p1305tc_pkg::result_item_t             result
);

    localparam logic [p1305tc_pkg::LIMB_W-1:0] LIMB_MASK = '1;
    localparam logic [2:0] LAST_IDX = 3'(p1305tc_pkg::NUM_LIMBS - 1);

    // Configuration
    logic [63:0] key_r_low_reg, key_r_high_reg;
    logic [63:0] key_s_low_reg, key_s_high_reg;
    logic [63:0] exp_low_reg, exp_high_reg;

    // Sequencer
    p1305tc_pkg::state_t state_reg, state_next;
    logic [2:0] row_reg, row_next;
    logic [2:0] col_reg, col_next;
    logic       last_reg;

    // Datapath
    logic [p1305tc_pkg::HLIMB_W-1:0] h_reg  [p1305tc_pkg::NUM_LIMBS];
    logic [p1305tc_pkg::OPA_W-1:0]   hm_reg [p1305tc_pkg::NUM_LIMBS];
    logic [p1305tc_pkg::HLIMB_W-1:0] fc_reg [p1305tc_pkg::NUM_LIMBS];
    logic [127:0]                    raw_tag_reg;
    p1305tc_pkg::result_item_t       result_reg;
    logic                            result_valid_reg;

    logic                            accept_in;
    logic                            out_load;
    logic [4:0]                      n_sat;
    logic [128:0]                    msg;
    logic [p1305tc_pkg::LIMB_W-1:0]  m_limb [p1305tc_pkg::NUM_LIMBS];
    logic [127:0]                    r_cl;
    logic [p1305tc_pkg::LIMB_W-1:0]  r_limb [p1305tc_pkg::NUM_LIMBS];
    logic [p1305tc_pkg::OPB_W-1:0]   s5     [p1305tc_pkg::NUM_LIMBS];
    logic [3:0]                      diff;
    logic [3:0]                      diff_r;
    logic [p1305tc_pkg::OPB_W-1:0]   coef;
    p1305tc_pkg::mac_ctl_t           mac_ctl;
    p1305tc_pkg::mac_res_t           mac_res;
    logic [40:0]                     fold_c5;
    logic [41:0]                     fold_sum;
    logic [p1305tc_pkg::HLIMB_W-1:0] fc_next [p1305tc_pkg::NUM_LIMBS];
    logic [127:0]                    raw_tag_next;
    logic [127:0]                    tag_sum;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_r_low_reg  <= '0;
            key_r_high_reg <= '0;
            key_s_low_reg  <= '0;
            key_s_high_reg <= '0;
            exp_low_reg    <= '0;
            exp_high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                p1305tc_pkg::CFG_R_LOW:    key_r_low_reg  <= cfg_data;
                p1305tc_pkg::CFG_R_HIGH:   key_r_high_reg <= cfg_data;
                p1305tc_pkg::CFG_S_LOW:    key_s_low_reg  <= cfg_data;
                p1305tc_pkg::CFG_S_HIGH:   key_s_high_reg <= cfg_data;
                p1305tc_pkg::CFG_TAG_LOW:  exp_low_reg    <= cfg_data;
                p1305tc_pkg::CFG_TAG_HIGH: exp_high_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Message padding and key limbs
    // ------------------------------------------------------------------
    assign accept_in = block_valid && block_ready;
    assign n_sat = (block.valid_bytes > 5'd16) ? 5'd16 : block.valid_bytes;

    // Keep the valid bytes and set a one just above them.
    always_comb
    begin
        msg = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < n_sat)
            begin
                msg[8*i +: 8] = (i < 8) ? block.block_low[8*(i%8) +: 8]
                                        : block.block_high[8*(i%8) +: 8];
            end
        end
        msg[{n_sat, 3'b000}] = 1'b1;
    end

    assign r_cl = {key_r_high_reg & p1305tc_pkg::CLAMP_HIGH,
                   key_r_low_reg & p1305tc_pkg::CLAMP_LOW};

    always_comb
    begin
        for (int i = 0; i < p1305tc_pkg::NUM_LIMBS - 1; i++)
        begin
            m_limb[i] = msg[p1305tc_pkg::LIMB_W*i +: p1305tc_pkg::LIMB_W];
            r_limb[i] = r_cl[p1305tc_pkg::LIMB_W*i +: p1305tc_pkg::LIMB_W];
        end
        m_limb[4] = {1'b0, msg[128:104]};
        r_limb[4] = {2'b00, r_cl[127:104]};
        for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
        begin
            s5[i] = {r_limb[i], 2'b00} + p1305tc_pkg::OPB_W'(r_limb[i]);
        end
    end

    // Row i, column j uses r[i-j] when j <= i and 5*r[i-j+5] otherwise.
    always_comb
    begin
        diff   = 4'(row_reg) + 4'd5 - 4'(col_reg);
        diff_r = diff - 4'd5;
        if (diff >= 4'd5)
        begin
            coef = p1305tc_pkg::OPB_W'(r_limb[diff_r[2:0]]);
        end
        else
        begin
            coef = s5[diff[2:0]];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            p1305tc_pkg::ST_IDLE:
            begin
                row_next = '0;
                col_next = '0;
                if (accept_in)
                begin
                    if (n_sat != 5'd0)
                    begin
                        state_next = p1305tc_pkg::ST_MUL;
                    end
                    else if (block.last_block)
                    begin
                        state_next = p1305tc_pkg::ST_FIN_CARRY;
                    end
                end
            end
            p1305tc_pkg::ST_MUL:
            begin
                if (col_reg == LAST_IDX)
                begin
                    col_next = '0;
                    row_next = row_reg + 3'd1;
                    if (row_reg == LAST_IDX)
                    begin
                        state_next = p1305tc_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + 3'd1;
                end
            end
            p1305tc_pkg::ST_DRAIN:
            begin
                if (mac_res.done && mac_res.row == LAST_IDX)
                begin
                    state_next = p1305tc_pkg::ST_FOLD;
                end
            end
            p1305tc_pkg::ST_FOLD:
            begin
                state_next = last_reg ? p1305tc_pkg::ST_FIN_CARRY : p1305tc_pkg::ST_IDLE;
            end
            p1305tc_pkg::ST_FIN_CARRY: state_next = p1305tc_pkg::ST_FIN_SUB;
            p1305tc_pkg::ST_FIN_SUB:   state_next = p1305tc_pkg::ST_FIN_OUT;
            p1305tc_pkg::ST_FIN_OUT:
            begin
                if (out_load)
                begin
                    state_next = p1305tc_pkg::ST_IDLE;
                end
            end
            default: state_next = p1305tc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        block_ready     = 1'b0;
        out_load        = 1'b0;
        mac_ctl.issue   = 1'b0;
        mac_ctl.first   = (col_reg == 3'd0);
        mac_ctl.chain   = (row_reg != 3'd0);
        mac_ctl.row_end = (col_reg == LAST_IDX);
        mac_ctl.row     = row_reg;
        mac_ctl.a       = hm_reg[col_reg];
        mac_ctl.b       = coef;
        case (state_reg)
            p1305tc_pkg::ST_IDLE:    block_ready   = 1'b1;
            p1305tc_pkg::ST_MUL:     mac_ctl.issue = 1'b1;
            p1305tc_pkg::ST_FIN_OUT: out_load      = !result_valid_reg || result_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= p1305tc_pkg::ST_IDLE;
            row_reg          <= '0;
            col_reg          <= '0;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (accept_in)
            begin
                last_reg <= block.last_block;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    p1305tc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .res   (mac_res)
    );

    // ------------------------------------------------------------------
    // Accumulator
    // ------------------------------------------------------------------
    // The top carry wraps around to limb 0 times five, since 2^130 = 5 mod p.
    assign fold_c5  = {1'b0, mac_res.acc[63:26], 2'b00} + 41'(mac_res.acc[63:26]);
    assign fold_sum = 42'(h_reg[0]) + 42'(fold_c5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
            begin
                h_reg[i] <= '0;
            end
        end
        else if (out_load)
        begin
            for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
            begin
                h_reg[i] <= '0;
            end
        end
        else if (state_reg == p1305tc_pkg::ST_FOLD)
        begin
            h_reg[0] <= {1'b0, fold_sum[25:0]};
            h_reg[1] <= h_reg[1] + 27'(fold_sum[41:26]);
        end
        else if (mac_res.done)
        begin
            h_reg[mac_res.row] <= {1'b0, mac_res.acc[p1305tc_pkg::LIMB_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
            begin
                hm_reg[i] <= p1305tc_pkg::OPA_W'(h_reg[i])
                           + p1305tc_pkg::OPA_W'(m_limb[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Final reduction
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [27:0] f [p1305tc_pkg::NUM_LIMBS];
        logic [27:0] c;
        for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
        begin
            f[i] = 28'(h_reg[i]);
        end
        for (int i = 1; i < p1305tc_pkg::NUM_LIMBS; i++)
        begin
            f[i]   = f[i] + (f[i-1] >> p1305tc_pkg::LIMB_W);
            f[i-1] = f[i-1] & 28'(LIMB_MASK);
        end
        c    = f[4] >> p1305tc_pkg::LIMB_W;
        f[4] = f[4] & 28'(LIMB_MASK);
        f[0] = f[0] + {c[25:0], 2'b00} + c;
        c    = f[0] >> p1305tc_pkg::LIMB_W;
        f[0] = f[0] & 28'(LIMB_MASK);
        f[1] = f[1] + c;
        c    = f[1] >> p1305tc_pkg::LIMB_W;
        f[1] = f[1] & 28'(LIMB_MASK);
        f[2] = f[2] + c;
        for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
        begin
            fc_next[i] = f[i][p1305tc_pkg::HLIMB_W-1:0];
        end
    end

    // Subtract p by adding 5 and checking the carry out of bit 130.
    always_comb
    begin
        logic [27:0] g [p1305tc_pkg::NUM_LIMBS];
        logic [27:0] sel [p1305tc_pkg::NUM_LIMBS];
        logic [27:0] c;
        c = 28'd5;
        for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
        begin
            g[i] = 28'(fc_reg[i]) + c;
            c    = g[i] >> p1305tc_pkg::LIMB_W;
            g[i] = g[i] & 28'(LIMB_MASK);
        end
        for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
        begin
            sel[i] = (c != 28'd0) ? g[i] : 28'(fc_reg[i]);
        end
        raw_tag_next[63:0]   = 64'(sel[0]) | (64'(sel[1]) << 26) | (64'(sel[2]) << 52);
        raw_tag_next[127:64] = 64'(sel[2] >> 12) | (64'(sel[3]) << 14)
                             | (64'(sel[4]) << 40);
    end

    assign tag_sum = raw_tag_reg + {key_s_high_reg, key_s_low_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == p1305tc_pkg::ST_FIN_CARRY)
        begin
            for (int i = 0; i < p1305tc_pkg::NUM_LIMBS; i++)
            begin
                fc_reg[i] <= fc_next[i];
            end
        end
        if (state_reg == p1305tc_pkg::ST_FIN_SUB)
        begin
            raw_tag_reg <= raw_tag_next;
        end
        if (out_load)
        begin
            result_reg.tag_low  <= tag_sum[63:0];
            result_reg.tag_high <= tag_sum[127:64];
            result_reg.accept   <= (tag_sum == {exp_high_reg, exp_low_reg});
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == p1305tc_pkg::ST_FIN_OUT))
        else $error("result appeared outside the finish step");

    a_clear_after_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (h_reg[0] == '0 && h_reg[1] == '0 && h_reg[2] == '0
                      && h_reg[3] == '0 && h_reg[4] == '0))
        else $error("accumulator not cleared after a tag transfer");

    a_last_row_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_res.done && mac_res.row == LAST_IDX) |-> state_reg == p1305tc_pkg::ST_DRAIN)
        else $error("final product row finished outside the drain step");

    a_empty_block_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && block.valid_bytes == 5'd0 && !block.last_block)
        |=> state_reg == p1305tc_pkg::ST_IDLE)
        else $error("empty non-final block started work");

endmodule
